// ----- rtl/core/eod_pkg.sv -----
// shared types and constants of the energy onset detector
package eod_pkg;

    localparam int E_W    = 48;
    localparam int SQ_W   = 31;
    localparam int GAIN_W = 16;
    localparam int GAP_W  = 8;
    localparam int DATA_W = 64;
    localparam int ADDR_W = 5;

    localparam logic [GAIN_W-1:0] GAIN_RESET  = 16'd333;
    localparam logic [GAP_W-1:0]  GAP_RESET   = 8'd4;
    localparam logic [GAP_W-1:0]  GAP_MAX     = 8'd255;
    localparam logic [E_W-1:0]    FLOOR_RESET = 48'h0000_8000_0000;
    localparam logic [E_W-1:0]    E_MAX       = 48'hFFFF_FFFF_FFFF;

    typedef enum logic [1:0] {
        REG_GAIN    = 2'd0,
        REG_MIN_GAP = 2'd1,
        REG_FLOOR   = 2'd2
    } reg_idx_t;

    typedef struct packed {
        logic signed [15:0] sample;
        logic               last_of_frame;
    } eod_in_t;

    typedef struct packed {
        logic           hit;
        logic [E_W-1:0] frame_energy;
    } eod_out_t;

endpackage

// ----- rtl/core/energy_onset_detector.sv -----
// energy onset detector: frame energy against a running history average
//
// sample channel: one signed q1.15 sample per request, last_of_frame marks
// the final sample of a frame. result channel: one request per frame with
// the hit flag and the saturated frame energy; other samples give nothing.
// the datapath is a five-register pipeline (input, square, accumulate,
// history and gain product, compare) so a sample is taken every cycle
// unless a stall holds the pipeline. the history ring is a memory with one
// write and one registered read a cycle; the entry at the ring pointer is
// fetched ahead of time, so frames may end back to back at one per cycle
// while no stall holds them.
// a stalled result holds in the output register while the stages behind it
// keep filling; non-final samples are folded into the accumulator, so input
// stall rises only once a frame end cannot move on.
// reset clears the pipeline, loads the register defaults and marks the
// whole history as floor-reset valued through a single ring-wrap flag, so
// no clearing pass is needed. apb writes complete with no wait state.
module energy_onset_detector #(
    parameter int HISTORY_DEPTH = 64
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             sample_valid,
    output logic                             sample_stall,
    input  eod_pkg::eod_in_t                 sample_data,
    output logic                             result_valid,
    input  logic                             result_stall,
    output eod_pkg::eod_out_t                result_data,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [eod_pkg::ADDR_W-1:0]       paddr,
    input  logic [eod_pkg::DATA_W-1:0]       pwdata,
    output logic [eod_pkg::DATA_W-1:0]       prdata,
    output logic                             pready
);
    import eod_pkg::*;

    localparam int PTR_W = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
    localparam int SUM_W = E_W + PTR_W;
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(HISTORY_DEPTH - 1);
    localparam logic [SUM_W-1:0] SUM_RESET = SUM_W'(HISTORY_DEPTH) << 31;

    // configuration
    logic [GAIN_W-1:0] gain_reg;
    logic [GAP_W-1:0]  min_gap_reg;
    logic [E_W-1:0]    floor_reg;
    logic              cfg_wr;

    // pipeline
    logic              a_v_reg, b_v_reg, c_v_reg, d_v_reg, out_v_reg;
    logic signed [15:0] a_sample_reg;
    logic              a_last_reg, b_last_reg;
    logic [SQ_W-1:0]   b_sq_reg;
    logic [E_W-1:0]    c_energy_reg, d_energy_reg;
    logic [39:0]       d_pp_lo_reg, d_pp_hi_reg;
    eod_out_t          out_reg;

    // state
    logic [E_W-1:0]    accum_reg, accum_next;
    logic [SUM_W-1:0]  sum_reg, sum_next;
    logic [PTR_W-1:0]  ptr_reg, ptr_next;
    logic              wrap_reg;
    logic [GAP_W-1:0]  gap_reg, gap_next;

    logic [E_W-1:0]    hist_mem [HISTORY_DEPTH];
    logic [E_W-1:0]    rd_reg;
    logic [PTR_W-1:0]  rd_addr;

    logic mv_out, d_free, mv_d, c_free, b_go, b_free, a_go, a_free;

    logic [15:0]       mag;
    logic [31:0]       sq_full;
    logic [E_W:0]      acc_sum;
    logic [E_W-1:0]    energy;
    logic [E_W-1:0]    avg_raw, avg, stored, old_entry;
    logic [39:0]       pp_lo_next, pp_hi_next;
    logic [63:0]       lhs, rhs;
    logic              hit_next;

    // handshake chain, from the output back to the input
    assign mv_out = d_v_reg && (!out_v_reg || !result_stall);
    assign d_free = !d_v_reg || mv_out;
    assign mv_d   = c_v_reg && d_free;
    assign c_free = !c_v_reg || mv_d;
    assign b_go   = b_v_reg && (!b_last_reg || c_free);
    assign b_free = !b_v_reg || b_go;
    assign a_go   = a_v_reg && b_free;
    assign a_free = !a_v_reg || a_go;

    assign sample_stall = !a_free;
    assign result_valid = out_v_reg;
    assign result_data  = out_reg;
    assign pready       = 1'b1;

    // config port
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_reg    <= GAIN_RESET;
            min_gap_reg <= GAP_RESET;
            floor_reg   <= FLOOR_RESET;
        end
        else if (cfg_wr)
        begin
            case (paddr[4:3])
                REG_GAIN:    gain_reg    <= pwdata[GAIN_W-1:0];
                REG_MIN_GAP: min_gap_reg <= pwdata[GAP_W-1:0];
                REG_FLOOR:   floor_reg   <= pwdata[E_W-1:0];
                default:     ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[4:3])
            REG_GAIN:    prdata = DATA_W'(gain_reg);
            REG_MIN_GAP: prdata = DATA_W'(min_gap_reg);
            REG_FLOOR:   prdata = DATA_W'(floor_reg);
            default:     prdata = '0;
        endcase
    end

    // square and accumulate
    assign mag     = a_sample_reg[15] ? (~a_sample_reg + 16'd1) : a_sample_reg;
    assign sq_full = mag * mag;
    assign acc_sum = {1'b0, accum_reg} + (E_W+1)'(b_sq_reg);
    assign energy  = acc_sum[E_W] ? E_MAX : acc_sum[E_W-1:0];

    always_comb
    begin
        accum_next = accum_reg;
        if (b_go)
        begin
            accum_next = b_last_reg ? '0 : energy;
        end
    end

    // history average, push and gain product
    assign avg_raw    = sum_reg[SUM_W-1:PTR_W];
    assign avg        = (avg_raw == '0) ? floor_reg : avg_raw;
    assign stored     = (c_energy_reg > floor_reg) ? c_energy_reg : floor_reg;
    // entries not yet reached since reset still hold the reset floor
    assign old_entry  = wrap_reg ? rd_reg : FLOOR_RESET;
    assign pp_lo_next = 40'(gain_reg) * 40'(avg[23:0]);
    assign pp_hi_next = 40'(gain_reg) * 40'(avg[47:24]);

    always_comb
    begin
        sum_next = sum_reg;
        ptr_next = ptr_reg;
        if (mv_d)
        begin
            sum_next = sum_reg - SUM_W'(old_entry) + SUM_W'(stored);
            ptr_next = (ptr_reg == PTR_LAST) ? '0 : ptr_reg + PTR_W'(1);
        end
    end

    // fetch the entry the next frame end will replace
    assign rd_addr = ptr_next;

    always_ff @(posedge clk)
    begin
        if (mv_d)
        begin
            hist_mem[ptr_reg] <= stored;
        end
        rd_reg <= hist_mem[rd_addr];
    end

    // threshold compare and gap counter
    assign lhs      = {8'b0, d_energy_reg, 8'b0};
    assign rhs      = {d_pp_hi_reg, 24'b0} + 64'(d_pp_lo_reg);
    assign hit_next = (lhs > rhs) && (gap_reg > min_gap_reg);

    always_comb
    begin
        gap_next = gap_reg;
        if (mv_out)
        begin
            if (hit_next)
            begin
                gap_next = '0;
            end
            else if (gap_reg != GAP_MAX)
            begin
                gap_next = gap_reg + GAP_W'(1);
            end
        end
    end

    // control and state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_v_reg   <= 1'b0;
            b_v_reg   <= 1'b0;
            c_v_reg   <= 1'b0;
            d_v_reg   <= 1'b0;
            out_v_reg <= 1'b0;
            accum_reg <= '0;
            sum_reg   <= SUM_RESET;
            ptr_reg   <= '0;
            wrap_reg  <= 1'b0;
            gap_reg   <= GAP_RESET;
        end
        else
        begin
            if (a_free)
            begin
                a_v_reg <= sample_valid;
            end
            if (b_free)
            begin
                b_v_reg <= a_v_reg;
            end
            if (c_free)
            begin
                c_v_reg <= b_v_reg && b_last_reg;
            end
            if (d_free)
            begin
                d_v_reg <= c_v_reg;
            end
            if (mv_out)
            begin
                out_v_reg <= 1'b1;
            end
            else if (!result_stall)
            begin
                out_v_reg <= 1'b0;
            end
            accum_reg <= accum_next;
            sum_reg   <= sum_next;
            ptr_reg   <= ptr_next;
            if (mv_d && ptr_reg == PTR_LAST)
            begin
                wrap_reg <= 1'b1;
            end
            gap_reg <= gap_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (a_free && sample_valid)
        begin
            a_sample_reg <= sample_data.sample;
            a_last_reg   <= sample_data.last_of_frame;
        end
        if (a_go)
        begin
            b_sq_reg   <= sq_full[SQ_W-1:0];
            b_last_reg <= a_last_reg;
        end
        if (b_go && b_last_reg)
        begin
            c_energy_reg <= energy;
        end
        if (mv_d)
        begin
            d_energy_reg <= c_energy_reg;
            d_pp_lo_reg  <= pp_lo_next;
            d_pp_hi_reg  <= pp_hi_next;
        end
        if (mv_out)
        begin
            out_reg.hit          <= hit_next;
            out_reg.frame_energy <= d_energy_reg;
        end
    end

`ifndef ASSERT_OFF
    // once the ring has wrapped every entry holds a written value
    a_wrap_stays: assert property (@(posedge clk) disable iff (!rst_n)
        !$fell(wrap_reg))
        else $error("history wrap flag dropped");

    a_ptr_range: assert property (@(posedge clk) disable iff (!rst_n)
        ptr_reg <= PTR_LAST)
        else $error("history pointer beyond depth");

    a_gap_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (mv_out && hit_next) |=> (gap_reg == '0 && result_data.hit))
        else $error("hit did not clear gap counter");

    a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (a_v_reg && b_v_reg && b_last_reg && c_v_reg && d_v_reg && out_v_reg
         && result_stall) |-> sample_stall)
        else $error("sample taken with a full stalled pipeline");
`endif

endmodule

// ----- sim/energy_onset_detector_tb.sv -----
`timescale 1ns / 1ps
// self-checking testbench of the energy onset detector: predicts frame energy and onsets
module energy_onset_detector_tb;
    import eod_pkg::*;

    localparam int HIST_DEPTH  = 64;
    localparam int HIST_SHIFT  = $clog2(HIST_DEPTH);
    localparam int CYCLE_LIMIT = 1_500_000;
    localparam int SETTLE      = 12;
    localparam int REG_SPARE   = 3;                // first address past the register file
    localparam int LOUD_LEN    = 40;               // longest frame of full-scale samples
    localparam int IDLE_PCT    = 6;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 sample_valid = 1'b0;
    logic                 sample_stall;
    eod_in_t              sample_data = '0;
    logic                 result_valid;
    logic                 result_stall = 1'b0;
    eod_out_t             result_data;
    logic                 psel = 1'b0;
    logic                 penable = 1'b0;
    logic                 pwrite = 1'b0;
    logic [ADDR_W-1:0]    paddr = '0;
    logic [DATA_W-1:0]    pwdata = '0;
    logic [DATA_W-1:0]    prdata;
    logic                 pready;

    // predicted detector state
    logic [GAIN_W-1:0]    gain_cfg;
    logic [GAP_W-1:0]     gap_min_cfg;
    logic [E_W-1:0]       floor_cfg;
    logic [E_W-1:0]       accum;
    logic [E_W-1:0]       history [HIST_DEPTH];
    logic [63:0]          history_sum;
    int unsigned          hist_ptr;
    logic [GAP_W-1:0]     frames_since_hit;

    eod_in_t              sample_q [$];
    eod_out_t             onset_q [$];
    eod_out_t             want_result;

    int unsigned          errors = 0;
    int unsigned          frames_checked = 0;
    int unsigned          hits_seen = 0;
    int unsigned          samples_sent = 0;
    int unsigned          cfg_writes = 0;
    int unsigned          cycles = 0;
    bit                   quiet_run = 1'b0;

    energy_onset_detector #(
        .HISTORY_DEPTH (HIST_DEPTH)
    ) u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .sample_data  (sample_data),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result_data  (result_data),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    task automatic reset_model();
        int i;
        gain_cfg         = GAIN_RESET;
        gap_min_cfg      = GAP_RESET;
        floor_cfg        = FLOOR_RESET;
        accum            = '0;
        for (i = 0; i < HIST_DEPTH; i++)
            history[i] = FLOOR_RESET;
        history_sum      = 64'(HIST_DEPTH) * 64'(FLOOR_RESET);
        hist_ptr         = 0;
        frames_since_hit = GAP_RESET;
    endtask

    // fold one accepted sample into the frame; a frame end yields the expected result
    task automatic track_sample(input eod_in_t s);
        logic [16:0]    mag;
        logic [E_W-1:0] sq;
        logic [E_W-1:0] energy;
        logic [E_W-1:0] avg;
        logic [E_W-1:0] stored;
        logic [63:0]    lhs;
        logic [63:0]    rhs;
        eod_out_t       res;
        mag = s.sample[15] ? 17'h10000 - {1'b0, s.sample} : {1'b0, s.sample};
        sq  = mag * mag;
        if (accum > E_MAX - sq)
            accum = E_MAX;
        else
            accum = accum + sq;
        if (!s.last_of_frame)
            return;
        energy = accum;
        accum  = '0;
        avg = E_W'(history_sum >> HIST_SHIFT);
        if (avg == '0)
            avg = floor_cfg;
        stored = (energy > floor_cfg) ? energy : floor_cfg;
        history_sum       = history_sum - 64'(history[hist_ptr]) + 64'(stored);
        history[hist_ptr] = stored;
        hist_ptr          = (hist_ptr + 1) % HIST_DEPTH;
        // energy > gain * avg / 256 without rounding
        lhs = {8'd0, energy, 8'd0};
        rhs = 64'(gain_cfg) * 64'(avg);
        res.hit = (lhs > rhs) && (frames_since_hit > gap_min_cfg);
        if (res.hit)
            frames_since_hit = '0;
        else if (frames_since_hit != GAP_MAX)
            frames_since_hit = frames_since_hit + 1'b1;
        res.frame_energy = energy;
        onset_q.push_back(res);
    endtask

    // sample driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sample_valid <= 1'b0;
            sample_data  <= '0;
        end
        else
        begin
            if (sample_valid && !sample_stall)
            begin
                track_sample(sample_data);
                samples_sent++;
            end
            if (!sample_valid || !sample_stall)
            begin
                if (sample_q.size() > 0 && (quiet_run || $urandom_range(99) >= IDLE_PCT))
                begin
                    sample_data  <= sample_q.pop_front();
                    sample_valid <= 1'b1;
                end
                else
                    sample_valid <= 1'b0;
            end
        end
    end

    // result monitor
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            result_stall <= 1'b0;
        else
        begin
            if (result_valid && !result_stall)
            begin
                if (onset_q.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected result, expected none actual hit=%0b energy=%0h",
                             $time, result_data.hit, result_data.frame_energy);
                end
                else
                begin
                    want_result = onset_q.pop_front();
                    frames_checked++;
                    if (want_result.hit)
                        hits_seen++;
                    if (result_data.hit !== want_result.hit)
                    begin
                        errors++;
                        $display("%0t: hit mismatch, expected %0b actual %0b",
                                 $time, want_result.hit, result_data.hit);
                    end
                    if (result_data.frame_energy !== want_result.frame_energy)
                    begin
                        errors++;
                        $display("%0t: frame_energy mismatch, expected %0h actual %0h",
                                 $time, want_result.frame_energy,
                                 result_data.frame_energy);
                    end
                end
            end
            result_stall <= !quiet_run && ($urandom_range(99) < IDLE_PCT);
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding", cycles, onset_q.size());
            $display("simulation failed");
            $finish;
        end
    end

    task automatic reg_write(input int idx, input logic [DATA_W-1:0] value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_W'(idx * 8);
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        cfg_writes++;
        // out-of-range indexes are dropped, values masked to the register width
        if (idx == int'(REG_GAIN))
            gain_cfg = value[GAIN_W-1:0];
        else if (idx == int'(REG_MIN_GAP))
            gap_min_cfg = value[GAP_W-1:0];
        else if (idx == int'(REG_FLOOR))
            floor_cfg = value[E_W-1:0];
    endtask

    function automatic logic [DATA_W-1:0] with_junk(input logic [DATA_W-1:0] value, input int w);
        logic [DATA_W-1:0] junk;
        junk = {$urandom(), $urandom()};
        return (junk << w) | value;
    endfunction

    task automatic queue_sample(input logic signed [15:0] v, input logic is_last);
        eod_in_t s;
        s.sample        = v;
        s.last_of_frame = is_last;
        sample_q.push_back(s);
    endtask

    // random frames: quiet stretches, loud bursts, silence and full-range noise
    task automatic queue_frames(input int n_samples);
        int             left;
        int             len;
        int             style;
        int             k;
        logic [15:0]    mag;
        logic [15:0]    v;
        left = n_samples;
        while (left > 0)
        begin
            len = ($urandom_range(19) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
            if (len > left)
                len = left;
            style = $urandom_range(9);
            for (k = 0; k < len; k++)
            begin
                if (style == 0)
                    v = '0;
                else if (style <= 4)
                    v = 16'($urandom_range(255)) - 16'd128;
                else if (style <= 6)
                    v = 16'($urandom());
                else
                begin
                    mag = 16'($urandom_range(16384, 32767));
                    v   = $urandom_range(1) ? -mag : mag;
                end
                queue_sample(v, k == len - 1);
            end
            left -= len;
        end
    endtask

    task automatic random_settings();
        logic [E_W-1:0] fl;
        int             pick;
        reg_write(int'(REG_GAIN), with_junk($urandom_range(3) == 0 ?
                  64'($urandom_range(65535)) : 64'($urandom_range(200, 700)), GAIN_W));
        reg_write(int'(REG_MIN_GAP), with_junk($urandom_range(7) == 0 ?
                  64'($urandom_range(255)) : 64'($urandom_range(6)), GAP_W));
        pick = $urandom_range(4);
        case (pick)
            0: fl = '0;
            1: fl = FLOOR_RESET;
            2: fl = E_W'($urandom_range(1, 1 << 20));
            3: fl = E_W'({$urandom(), $urandom()});
            default: fl = E_W'($urandom_range(1, 8)) << 30;
        endcase
        reg_write(int'(REG_FLOOR), with_junk(64'(fl), E_W));
        if ($urandom_range(1))
            reg_write(REG_SPARE, {$urandom(), $urandom()});
    endtask

    task automatic wait_idle();
        while (sample_q.size() != 0 || sample_valid || onset_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    initial
    begin
        int n;
        reset_model();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // default settings: silence, both sample extremes, mixed signs, loud burst
        queue_sample(16'sd0, 1'b1);
        queue_sample(-16'sd32768, 1'b1);
        queue_sample(16'sd32767, 1'b1);
        queue_sample(-16'sd1, 1'b0);
        queue_sample(16'sd1, 1'b0);
        queue_sample(-16'sd32768, 1'b0);
        queue_sample(16'sd32767, 1'b1);
        for (n = 0; n < 7; n++)
            queue_sample(-16'sd32768, n == 6);
        // a similar burst right after an onset: gap counter just cleared
        for (n = 0; n < 6; n++)
            queue_sample(16'sd32767, n == 5);
        queue_frames(120);
        wait_idle();

        // zero floor and zero gain; flush the history with silent frames
        reg_write(int'(REG_GAIN), with_junk(64'd0, GAIN_W));
        reg_write(int'(REG_MIN_GAP), with_junk(64'd0, GAP_W));
        reg_write(int'(REG_FLOOR), with_junk(64'd0, E_W));
        for (n = 0; n < HIST_DEPTH + 6; n++)
            queue_sample(16'sd0, 1'b1);
        queue_sample(16'sd1, 1'b1);
        queue_frames(80);
        wait_idle();

        // long full-scale frame with top settings, no idling on either side
        quiet_run = 1'b1;
        reg_write(int'(REG_GAIN), with_junk(64'hFFFF, GAIN_W));
        reg_write(int'(REG_MIN_GAP), with_junk(64'hFF, GAP_W));
        reg_write(int'(REG_FLOOR), with_junk(64'(E_MAX), E_W));
        for (n = 0; n < LOUD_LEN; n++)
            queue_sample(-16'sd32768, n == LOUD_LEN - 1);
        queue_frames(60);
        wait_idle();
        quiet_run = 1'b0;

        // randomized settings between batches
        for (n = 0; n < 4; n++)
        begin
            random_settings();
            queue_frames(90);
            wait_idle();
        end

        $display("covered %0d samples in %0d frames with %0d onsets", samples_sent,
                 frames_checked, hits_seen);
        $display("across %0d register writes including extremes and dropped addresses",
                 cfg_writes);
        if (errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
